// ===== hdl/kti_pkg.sv =====
// Shared constants, types and helpers of the keyframe table interpolator.
package kti_pkg;

  localparam int MAX_KEYS = 64;
  localparam int NUM_CH   = 25;

  localparam int CMD_W  = 4;
  localparam int FRM_W  = 16;
  localparam int CH_W   = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam int POS_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int CC_W  = $clog2(NUM_CH);
  localparam int CA_W  = $clog2(MAX_KEYS * NUM_CH);

  localparam int NUM_W = VAL_W + FRM_W;
  localparam int QUO_W = VAL_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_CH    = 4'd0,
    CMD_ADD_KEY   = 4'd1,
    CMD_REMOVE    = 4'd2,
    CMD_NEXT_KEY  = 4'd3,
    CMD_PREV_KEY  = 4'd4,
    CMD_EVALUATE  = 4'd5,
    CMD_FIRST_LST = 4'd6,
    CMD_CLEAR_CUR = 4'd7,
    CMD_RESET_ALL = 4'd8
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_DISPATCH,
    S_RM_RD,
    S_RM_WR,
    S_RM_TAIL,
    S_FREE_RD,
    S_FREE_CK,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_COPY,
    S_EV_RDP,
    S_EV_P,
    S_EV_RDN,
    S_EV_N,
    S_EV_MUL,
    S_EV_DIVS,
    S_EV_DIV,
    S_EMIT
  } state_e;

  // One entry of the sorted directory: key frame, enable bit and data slot.
  typedef struct packed {
    logic [FRM_W-1:0] frame;
    logic             en;
    logic [POS_W-1:0] slot;
  } dir_t;

  localparam int DIR_W = $bits(dir_t);

  function automatic logic [CA_W-1:0] chan_addr(input logic [POS_W-1:0] s,
                                                input logic [CC_W-1:0]  c);
    logic [CA_W-1:0] base;
    base = CA_W'(s) * CA_W'(NUM_CH);
    return base + CA_W'(c);
  endfunction

endpackage

// ===== hdl/kti_in_if.sv =====
// Command channel of the keyframe table interpolator.
interface kti_in_if;
  import kti_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [FRM_W-1:0]        frame;
  logic                    key_enable;
  logic [CH_W-1:0]         channel;
  logic signed [VAL_W-1:0] channel_value;

  modport source (output valid, command, frame, key_enable, channel, channel_value,
                  input ready);
  modport sink (input valid, command, frame, key_enable, channel, channel_value,
                output ready);
endinterface

// ===== hdl/kti_out_if.sv =====
// Result channel of the keyframe table interpolator.
interface kti_out_if;
  import kti_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [FRM_W-1:0]        found_frame;
  logic [FRM_W-1:0]        last_frame;
  logic [CH_W-1:0]         out_channel;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_enable;
  logic                    last;

  modport source (output valid, status, found_frame, last_frame, out_channel, out_value,
                  out_enable, last, input ready);
  modport sink (input valid, status, found_frame, last_frame, out_channel, out_value,
                out_enable, last, output ready);
endinterface

// ===== hdl/kti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/kti_div.sv =====
// Restoring divider, one quotient bit per cycle.
module kti_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kti_pkg::NUM_W-1:0] num_i,
  input  logic [kti_pkg::FRM_W-1:0] den_i,
  output logic                      done_o,
  output logic [kti_pkg::QUO_W-1:0] quo_o
);
  import kti_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  nq_q, nq_d;
  logic [FRM_W:0]    rem_q, rem_d;
  logic [FRM_W-1:0]  den_q, den_d;
  logic [FRM_W:0]    trial;
  logic [FRM_W:0]    diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[FRM_W-1:0], nq_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // shift in the next numerator bit; subtract where the divisor fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff;
        nq_d  = {nq_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        nq_d  = {nq_q[NUM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q[QUO_W-1:0];
endmodule

// ===== hdl/keyframe_table_interpolator.sv =====
// Keyframe table with linear interpolation: sequencer, stores and result register.
//
// Usage: one command per transaction on in_i; results leave on out_o, the final
// one of each command marked by last. evaluate on a non-empty table gives one
// transaction per channel in index order; every other command gives exactly one.
// in_i.ready is high only while the sequencer is idle, so one command is worked
// at a time. A finished result waits in the output register, and the next
// command is taken while it waits.
// set_channel, clear_current, reset_all and unknown codes go straight to the emit
// step. Searching commands first scan the sorted key directory, one stored key
// per read (directory RAM with registered read). Insert and remove then shift
// the directory one moved entry at a time; add_key copies the current node one
// channel at a time. evaluate reads each channel of a copied key directly and,
// when interpolating, waits per channel on the serial divider (48 steps).
// Reset empties the table and zeroes the current node at once; no clearing pass
// runs, since stored keys are held in RAM slots tracked by a high-water mark.
// A stalled receiver holds the output register, and the sequencer waits in its
// emit step until the result is taken.
module keyframe_table_interpolator (
  input  logic      clk_i,
  input  logic      rst_ni,
  kti_in_if.sink    in_i,
  kti_out_if.source out_o
);
  import kti_pkg::*;

  // ---- control state
  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;   // keys stored
  logic [CNT_W-1:0] hw_q, hw_d;     // directory positions ever written
  logic [CNT_W-1:0] i_q, i_d;
  logic [CC_W-1:0]  c_q, c_d;
  logic signed [VAL_W-1:0] cur_q [NUM_CH];
  logic signed [VAL_W-1:0] cur_d [NUM_CH];
  logic             cur_en_q, cur_en_d;
  logic             ov_q, ov_d;

  // ---- working registers
  logic [FRM_W-1:0] f_q, f_d;
  logic             ken_q, ken_d;
  logic             hit_q, hit_d, lt_q, lt_d, gt_q, gt_d, ge_seen_q, ge_seen_d;
  logic [CNT_W-1:0] ge_pos_q, ge_pos_d;
  logic [POS_W-1:0] hit_pos_q, hit_pos_d;
  dir_t             hit_e_q, hit_e_d, lt_e_q, lt_e_d, gt_e_q, gt_e_d;
  dir_t             first_e_q, first_e_d, last_e_q, last_e_d;
  logic [POS_W-1:0] free_q, free_d, sel_q, sel_d;
  logic             interp_q, interp_d, pev_q, pev_d;
  logic signed [VAL_W-1:0] vp_q, vp_d, pval_q, pval_d;
  logic [VAL_W-1:0] mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] mul_q, mul_d;
  status_e          pst_q, pst_d;
  logic [FRM_W-1:0] pff_q, pff_d, plf_q, plf_d;

  // ---- output register
  status_e          o_st_q, o_st_d;
  logic [FRM_W-1:0] o_ff_q, o_ff_d, o_lf_q, o_lf_d;
  logic [CH_W-1:0]  o_ch_q, o_ch_d;
  logic signed [VAL_W-1:0] o_val_q, o_val_d;
  logic             o_en_q, o_en_d, o_last_q, o_last_d;

  // ---- memories and divider
  logic             dir_we;
  logic [POS_W-1:0] dir_waddr, dir_raddr;
  dir_t             dir_wdata, dir_rd;
  logic [DIR_W-1:0] dir_rdata;
  logic             ch_we;
  logic [CA_W-1:0]  ch_waddr, ch_raddr;
  logic [VAL_W-1:0] ch_wdata, ch_rdata;
  logic             div_start, div_done;
  logic [QUO_W-1:0] div_quo;

  // ---- combinational helpers
  logic             accept, out_free;
  logic [FRM_W-1:0] t_frm, den_frm;
  logic signed [VAL_W:0]   d33;
  logic signed [VAL_W+1:0] sq, r34;

  kti_ram #(.WIDTH(DIR_W), .DEPTH(MAX_KEYS)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  kti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS * NUM_CH)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  kti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_q),
    .den_i   (den_frm),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign dir_rd   = dir_t'(dir_rdata);
  assign in_i.ready = (state_q == S_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign t_frm    = f_q - lt_e_q.frame;
  assign den_frm  = gt_e_q.frame - lt_e_q.frame;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    hw_d      = hw_q;
    i_d       = i_q;
    c_d       = c_q;
    cur_d     = cur_q;
    cur_en_d  = cur_en_q;
    f_d       = f_q;
    ken_d     = ken_q;
    hit_d     = hit_q;
    lt_d      = lt_q;
    gt_d      = gt_q;
    ge_seen_d = ge_seen_q;
    ge_pos_d  = ge_pos_q;
    hit_pos_d = hit_pos_q;
    hit_e_d   = hit_e_q;
    lt_e_d    = lt_e_q;
    gt_e_d    = gt_e_q;
    first_e_d = first_e_q;
    last_e_d  = last_e_q;
    free_d    = free_q;
    sel_d     = sel_q;
    interp_d  = interp_q;
    pev_d     = pev_q;
    vp_d      = vp_q;
    pval_d    = pval_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    mul_d     = mul_q;
    pst_d     = pst_q;
    pff_d     = pff_q;
    plf_d     = plf_q;
    ov_d      = ov_q;
    o_st_d    = o_st_q;
    o_ff_d    = o_ff_q;
    o_lf_d    = o_lf_q;
    o_ch_d    = o_ch_q;
    o_val_d   = o_val_q;
    o_en_d    = o_en_q;
    o_last_d  = o_last_q;
    dir_we    = 1'b0;
    dir_waddr = '0;
    dir_wdata = '0;
    dir_raddr = '0;
    ch_we     = 1'b0;
    ch_waddr  = '0;
    ch_wdata  = '0;
    ch_raddr  = '0;
    div_start = 1'b0;
    d33       = {ch_rdata[VAL_W-1], ch_rdata} - {vp_q[VAL_W-1], vp_q};
    sq        = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    r34       = {{2{vp_q[VAL_W-1]}}, vp_q} + sq;

    if (out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_e'(in_i.command);
          f_d       = in_i.frame;
          ken_d     = in_i.key_enable;
          pst_d     = ST_OK;
          pff_d     = '0;
          plf_d     = '0;
          pev_d     = 1'b0;
          hit_d     = 1'b0;
          lt_d      = 1'b0;
          gt_d      = 1'b0;
          ge_seen_d = 1'b0;
          ge_pos_d  = cnt_q;
          i_d       = '0;
          state_d   = S_EMIT;
          case (in_i.command)
            CMD_SET_CH: begin
              if (in_i.channel < CH_W'(NUM_CH)) begin
                cur_d[in_i.channel[CC_W-1:0]] = in_i.channel_value;
              end
            end
            CMD_CLEAR_CUR, CMD_RESET_ALL: begin
              for (int k = 0; k < NUM_CH; k++) begin
                cur_d[k] = '0;
              end
              cur_en_d = 1'b0;
              if (in_i.command == CMD_RESET_ALL) begin
                cnt_d = '0;
              end
            end
            CMD_ADD_KEY, CMD_REMOVE, CMD_NEXT_KEY, CMD_PREV_KEY, CMD_EVALUATE,
            CMD_FIRST_LST: begin
              // frame zero is raised to one on add
              if (in_i.command == CMD_ADD_KEY && in_i.frame == '0) begin
                f_d = FRM_W'(1);
              end
              state_d = (cnt_q == '0) ? S_DISPATCH : S_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        dir_raddr = i_q[POS_W-1:0];
        state_d   = S_SCAN_CK;
      end

      S_SCAN_CK: begin
        if (i_q == '0) begin
          first_e_d = dir_rd;
        end
        last_e_d = dir_rd;
        if (dir_rd.frame < f_q) begin
          lt_d   = 1'b1;
          lt_e_d = dir_rd;
        end
        if (dir_rd.frame > f_q && !gt_q) begin
          gt_d   = 1'b1;
          gt_e_d = dir_rd;
        end
        if (dir_rd.frame == f_q) begin
          hit_d     = 1'b1;
          hit_pos_d = i_q[POS_W-1:0];
          hit_e_d   = dir_rd;
        end
        if (dir_rd.frame >= f_q && !ge_seen_q) begin
          ge_seen_d = 1'b1;
          ge_pos_d  = i_q;
        end
        i_d     = i_q + 1'b1;
        state_d = (i_q == cnt_q - 1'b1) ? S_DISPATCH : S_SCAN_RD;
      end

      S_DISPATCH: begin
        state_d = S_EMIT;
        case (cmd_q)
          CMD_NEXT_KEY: begin
            if (cnt_q == '0) pst_d = ST_EMPTY;
            else pff_d = gt_q ? gt_e_q.frame : first_e_q.frame;
          end
          CMD_PREV_KEY: begin
            if (cnt_q == '0) pst_d = ST_EMPTY;
            else pff_d = lt_q ? lt_e_q.frame : last_e_q.frame;
          end
          CMD_FIRST_LST: begin
            if (cnt_q != '0) begin
              pff_d = first_e_q.frame;
              plf_d = last_e_q.frame;
            end
          end
          CMD_REMOVE: begin
            if (cnt_q == '0) begin
              pst_d = ST_EMPTY;
            end else if (!hit_q) begin
              pst_d = ST_NOT_FOUND;
            end else begin
              // close the gap, then park the freed slot past the end
              i_d     = CNT_W'(hit_pos_q);
              free_d  = hit_e_q.slot;
              state_d = (CNT_W'(hit_pos_q) + 1'b1 < cnt_q) ? S_RM_RD : S_RM_TAIL;
            end
          end
          CMD_ADD_KEY: begin
            if (hit_q) begin
              dir_we    = 1'b1;
              dir_waddr = hit_pos_q;
              dir_wdata = '{frame: f_q, en: cur_en_q, slot: hit_e_q.slot};
              sel_d     = hit_e_q.slot;
              c_d       = '0;
              state_d   = S_COPY;
            end else if (cnt_q == CNT_W'(MAX_KEYS)) begin
              pst_d = ST_FULL;
            end else if (cnt_q < hw_q) begin
              state_d = S_FREE_RD;
            end else begin
              free_d  = cnt_q[POS_W-1:0];
              i_d     = cnt_q;
              state_d = (cnt_q > ge_pos_q) ? S_INS_RD : S_INS_PUT;
            end
          end
          CMD_EVALUATE: begin
            if (cnt_q == '0) begin
              pst_d = ST_EMPTY;
            end else begin
              c_d      = '0;
              interp_d = 1'b0;
              state_d  = S_EV_RDP;
              if (hit_q) begin
                sel_d    = hit_e_q.slot;
                cur_en_d = hit_e_q.en;
              end else if (!lt_q) begin
                sel_d    = first_e_q.slot;
                cur_en_d = first_e_q.en;
              end else if (!gt_q) begin
                sel_d    = last_e_q.slot;
                cur_en_d = last_e_q.en;
              end else begin
                interp_d = 1'b1;
                cur_en_d = lt_e_q.en;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_RM_RD: begin
        dir_raddr = POS_W'(i_q + 1'b1);
        state_d   = S_RM_WR;
      end

      S_RM_WR: begin
        dir_we    = 1'b1;
        dir_waddr = i_q[POS_W-1:0];
        dir_wdata = dir_rd;
        i_d       = i_q + 1'b1;
        state_d   = (i_q + CNT_W'(2) < cnt_q) ? S_RM_RD : S_RM_TAIL;
      end

      S_RM_TAIL: begin
        dir_we    = 1'b1;
        dir_waddr = POS_W'(cnt_q - 1'b1);
        dir_wdata = '{frame: '0, en: 1'b0, slot: free_q};
        cnt_d     = cnt_q - 1'b1;
        state_d   = S_EMIT;
      end

      S_FREE_RD: begin
        dir_raddr = cnt_q[POS_W-1:0];
        state_d   = S_FREE_CK;
      end

      S_FREE_CK: begin
        free_d  = dir_rd.slot;
        i_d     = cnt_q;
        state_d = (cnt_q > ge_pos_q) ? S_INS_RD : S_INS_PUT;
      end

      S_INS_RD: begin
        dir_raddr = POS_W'(i_q - 1'b1);
        state_d   = S_INS_WR;
      end

      S_INS_WR: begin
        dir_we    = 1'b1;
        dir_waddr = i_q[POS_W-1:0];
        dir_wdata = dir_rd;
        i_d       = i_q - 1'b1;
        state_d   = (i_q - 1'b1 > ge_pos_q) ? S_INS_RD : S_INS_PUT;
      end

      S_INS_PUT: begin
        dir_we    = 1'b1;
        dir_waddr = ge_pos_q[POS_W-1:0];
        dir_wdata = '{frame: f_q, en: ken_q, slot: free_q};
        sel_d     = free_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q >= hw_q) begin
          hw_d = cnt_q + 1'b1;
        end
        c_d     = '0;
        state_d = S_COPY;
      end

      S_COPY: begin
        ch_we    = 1'b1;
        ch_waddr = chan_addr(sel_q, c_q);
        ch_wdata = cur_q[c_q];
        c_d      = c_q + 1'b1;
        if (c_q == CC_W'(NUM_CH - 1)) begin
          state_d = S_EMIT;
        end
      end

      S_EV_RDP: begin
        ch_raddr = chan_addr(interp_q ? lt_e_q.slot : sel_q, c_q);
        state_d  = S_EV_P;
      end

      S_EV_P: begin
        vp_d = ch_rdata;
        if (interp_q) begin
          state_d = S_EV_RDN;
        end else begin
          pval_d     = ch_rdata;
          cur_d[c_q] = ch_rdata;
          pev_d      = 1'b1;
          state_d    = S_EMIT;
        end
      end

      S_EV_RDN: begin
        ch_raddr = chan_addr(gt_e_q.slot, c_q);
        state_d  = S_EV_N;
      end

      S_EV_N: begin
        // split the difference into sign and magnitude
        neg_d   = d33[VAL_W];
        mag_d   = d33[VAL_W] ? VAL_W'(-d33) : d33[VAL_W-1:0];
        state_d = S_EV_MUL;
      end

      S_EV_MUL: begin
        mul_d   = NUM_W'(mag_q) * NUM_W'(t_frm);
        state_d = S_EV_DIVS;
      end

      S_EV_DIVS: begin
        div_start = 1'b1;
        state_d   = S_EV_DIV;
      end

      S_EV_DIV: begin
        if (div_done) begin
          pval_d     = r34[VAL_W-1:0];
          cur_d[c_q] = r34[VAL_W-1:0];
          pev_d      = 1'b1;
          state_d    = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (pev_q) begin
            o_st_d   = ST_OK;
            o_ff_d   = '0;
            o_lf_d   = '0;
            o_ch_d   = CH_W'(c_q);
            o_val_d  = pval_q;
            o_en_d   = cur_en_q;
            o_last_d = (c_q == CC_W'(NUM_CH - 1));
          end else begin
            o_st_d   = pst_q;
            o_ff_d   = pff_q;
            o_lf_d   = plf_q;
            o_ch_d   = '0;
            o_val_d  = '0;
            o_en_d   = 1'b0;
            o_last_d = 1'b1;
          end
          // advance to the next channel, or finish the command
          if (pev_q && c_q != CC_W'(NUM_CH - 1)) begin
            c_d     = c_q + 1'b1;
            pev_d   = 1'b0;
            state_d = S_EV_RDP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hw_q     <= '0;
      cur_en_q <= 1'b0;
      ov_q     <= 1'b0;
      pev_q    <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        cur_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hw_q     <= hw_d;
      cur_en_q <= cur_en_d;
      ov_q     <= ov_d;
      pev_q    <= pev_d;
      cur_q    <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    i_q       <= i_d;
    c_q       <= c_d;
    f_q       <= f_d;
    ken_q     <= ken_d;
    hit_q     <= hit_d;
    lt_q      <= lt_d;
    gt_q      <= gt_d;
    ge_seen_q <= ge_seen_d;
    ge_pos_q  <= ge_pos_d;
    hit_pos_q <= hit_pos_d;
    hit_e_q   <= hit_e_d;
    lt_e_q    <= lt_e_d;
    gt_e_q    <= gt_e_d;
    first_e_q <= first_e_d;
    last_e_q  <= last_e_d;
    free_q    <= free_d;
    sel_q     <= sel_d;
    interp_q  <= interp_d;
    vp_q      <= vp_d;
    pval_q    <= pval_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    mul_q     <= mul_d;
    pst_q     <= pst_d;
    pff_q     <= pff_d;
    plf_q     <= plf_d;
    o_st_q    <= o_st_d;
    o_ff_q    <= o_ff_d;
    o_lf_q    <= o_lf_d;
    o_ch_q    <= o_ch_d;
    o_val_q   <= o_val_d;
    o_en_q    <= o_en_d;
    o_last_q  <= o_last_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = o_st_q;
  assign out_o.found_frame = o_ff_q;
  assign out_o.last_frame  = o_lf_q;
  assign out_o.out_channel = o_ch_q;
  assign out_o.out_value   = o_val_q;
  assign out_o.out_enable  = o_en_q;
  assign out_o.last        = o_last_q;

  // slot permutation relies on every stored key lying below the high-water mark
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= hw_q)
    else $error("key count above high-water mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni) hw_q <= CNT_W'(MAX_KEYS))
    else $error("high-water mark beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_done |-> state_q == S_EV_DIV)
    else $error("divider finished outside interpolation");
endmodule

// ===== test/kti_checker.sv =====
// Result checker: predicts the keyframe table and compares every result transaction.
`timescale 1ns / 100ps
module kti_checker
  import kti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kti_in_if    mon_in,
  kti_out_if   mon_out,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic [FRM_W-1:0]        found_frame;
    logic [FRM_W-1:0]        last_frame;
    logic [CH_W-1:0]         out_channel;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_enable;
    logic                    last;
  } result_t;

  result_t results_due[$];

  logic [FRM_W-1:0]        tbl_frame [MAX_KEYS];
  logic                    tbl_en    [MAX_KEYS];
  logic signed [VAL_W-1:0] tbl_val   [MAX_KEYS][NUM_CH];
  int                      tbl_count;
  logic signed [VAL_W-1:0] node_val  [NUM_CH];
  logic                    node_en;
  logic [FRM_W-1:0]        node_frame;

  function automatic result_t status_result(logic [STAT_W-1:0] st, logic [FRM_W-1:0] ff,
                                            logic [FRM_W-1:0] lf);
    result_t r;
    r.status = st;
    r.found_frame = ff;
    r.last_frame = lf;
    r.out_channel = '0;
    r.out_value = '0;
    r.out_enable = 1'b0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic clear_node();
    for (int c = 0; c < NUM_CH; c++) node_val[c] = '0;
    node_en = 1'b0;
    node_frame = '0;
  endtask

  function automatic int find_frame(logic [FRM_W-1:0] f);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_frame[i] == f) return i;
    return -1;
  endfunction

  task automatic store_key(logic [FRM_W-1:0] f_in, logic en, output logic [STAT_W-1:0] st);
    logic [FRM_W-1:0] f;
    int hit, pos;
    st = ST_OK;
    f = (f_in == 0) ? 16'd1 : f_in;
    hit = find_frame(f);
    if (hit >= 0) begin
      // overwrite keeps the frame, takes the node's enable, not the command's
      for (int c = 0; c < NUM_CH; c++) tbl_val[hit][c] = node_val[c];
      tbl_en[hit] = node_en;
    end else if (tbl_count >= MAX_KEYS) begin
      st = ST_FULL;
    end else begin
      pos = 0;
      while (pos < tbl_count && tbl_frame[pos] <= f) pos++;
      for (int i = tbl_count; i > pos; i--) begin
        tbl_frame[i] = tbl_frame[i-1];
        tbl_en[i] = tbl_en[i-1];
        for (int c = 0; c < NUM_CH; c++) tbl_val[i][c] = tbl_val[i-1][c];
      end
      tbl_frame[pos] = f;
      tbl_en[pos] = en;
      for (int c = 0; c < NUM_CH; c++) tbl_val[pos][c] = node_val[c];
      tbl_count++;
    end
  endtask

  task automatic drop_key(logic [FRM_W-1:0] f, output logic [STAT_W-1:0] st);
    int hit;
    st = ST_OK;
    hit = find_frame(f);
    if (tbl_count == 0) st = ST_EMPTY;
    else if (hit < 0) st = ST_NOT_FOUND;
    else begin
      for (int i = hit; i + 1 < tbl_count; i++) begin
        tbl_frame[i] = tbl_frame[i+1];
        tbl_en[i] = tbl_en[i+1];
        for (int c = 0; c < NUM_CH; c++) tbl_val[i][c] = tbl_val[i+1][c];
      end
      tbl_count--;
    end
  endtask

  // Rebuild the node at frame f: copy an exact key, hold the ends, else interpolate.
  task automatic rebuild_node(logic [FRM_W-1:0] f);
    int p, n, hit;
    bit below, above;
    longint vp, vn, r, fp, fn;
    p = 0; n = 0; hit = -1; below = 0; above = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_frame[i] == f) begin
        hit = i;
        break;
      end
      if (tbl_frame[i] < f) begin
        p = i;
        below = 1;
      end else begin
        n = i;
        above = 1;
        break;
      end
    end
    if (hit >= 0) begin
      for (int c = 0; c < NUM_CH; c++) node_val[c] = tbl_val[hit][c];
      node_en = tbl_en[hit];
    end else begin
      if (!below) begin
        p = 0; n = 0;
      end else if (!above) begin
        p = tbl_count - 1; n = p;
      end
      node_en = tbl_en[p];
      fp = longint'(tbl_frame[p]);
      fn = longint'(tbl_frame[n]);
      for (int c = 0; c < NUM_CH; c++) begin
        vp = longint'(tbl_val[p][c]);
        vn = longint'(tbl_val[n][c]);
        r = vp;
        if (n != p) r = vp + ((vn - vp) * (longint'(f) - fp)) / (fn - fp);
        node_val[c] = r[VAL_W-1:0];
      end
    end
    node_frame = f;
  endtask

  task automatic predict(logic [CMD_W-1:0] cmd, logic [FRM_W-1:0] f, logic en,
                         logic [CH_W-1:0] ch, logic signed [VAL_W-1:0] val);
    logic [STAT_W-1:0] st;
    logic [FRM_W-1:0] ff, lf;
    result_t r;
    st = ST_OK; ff = '0; lf = '0;
    case (cmd)
      CMD_SET_CH: begin
        if (ch < NUM_CH) node_val[ch] = val;
      end
      CMD_ADD_KEY: store_key(f, en, st);
      CMD_REMOVE: drop_key(f, st);
      CMD_NEXT_KEY: begin
        if (tbl_count == 0) st = ST_EMPTY;
        else begin
          // wrap to the first key when nothing lies above
          ff = tbl_frame[0];
          for (int i = 0; i < tbl_count; i++)
            if (tbl_frame[i] > f) begin
              ff = tbl_frame[i];
              break;
            end
        end
      end
      CMD_PREV_KEY: begin
        if (tbl_count == 0) st = ST_EMPTY;
        else begin
          ff = tbl_frame[tbl_count-1];
          for (int i = tbl_count - 1; i >= 0; i--)
            if (tbl_frame[i] < f) begin
              ff = tbl_frame[i];
              break;
            end
        end
      end
      CMD_EVALUATE: begin
        if (tbl_count == 0) st = ST_EMPTY;
        else begin
          rebuild_node(f);
          for (int c = 0; c < NUM_CH; c++) begin
            r = status_result(ST_OK, '0, '0);
            r.out_channel = CH_W'(c);
            r.out_value = node_val[c];
            r.out_enable = node_en;
            r.last = (c == NUM_CH - 1);
            results_due.push_back(r);
          end
          return;
        end
      end
      CMD_FIRST_LST: begin
        if (tbl_count != 0) begin
          ff = tbl_frame[0];
          lf = tbl_frame[tbl_count-1];
        end
      end
      CMD_CLEAR_CUR: clear_node();
      CMD_RESET_ALL: begin
        tbl_count = 0;
        clear_node();
      end
      default: ;
    endcase
    results_due.push_back(status_result(st, ff, lf));
  endtask

  task automatic report(string field, longint want, longint got);
    $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t w;
    if (!rst_ni) begin
      results_due.delete();
      tbl_count = 0;
      clear_node();
      fail_count = 0;
      pending = 0;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result transaction with nothing outstanding, value 0x%0h",
                   $time, mon_out.out_value);
          fail_count++;
        end else begin
          w = results_due.pop_front();
          if (mon_out.status !== w.status) report("status", w.status, mon_out.status);
          if (mon_out.found_frame !== w.found_frame)
            report("found_frame", w.found_frame, mon_out.found_frame);
          if (mon_out.last_frame !== w.last_frame)
            report("last_frame", w.last_frame, mon_out.last_frame);
          if (mon_out.out_channel !== w.out_channel)
            report("out_channel", w.out_channel, mon_out.out_channel);
          if (mon_out.out_value !== w.out_value)
            report("out_value", w.out_value, mon_out.out_value);
          if (mon_out.out_enable !== w.out_enable)
            report("out_enable", w.out_enable, mon_out.out_enable);
          if (mon_out.last !== w.last) report("last", w.last, mon_out.last);
        end
      end
      if (mon_in.valid && mon_in.ready)
        predict(mon_in.command, mon_in.frame, mon_in.key_enable, mon_in.channel,
                mon_in.channel_value);
      pending = results_due.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the keyframe table interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import kti_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  int   tx_idle;    // percent of commands preceded by a gap
  int   rx_idle;    // percent of cycles the receiver refuses results
  logic hold_start; // pulse: receiver holds off for a long stretch
  int   sent;
  int   evals;

  kti_in_if  in_ch ();
  kti_out_if out_ch ();

  keyframe_table_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  kti_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mon_in     (in_ch),
    .mon_out    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    int hold_left;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_start) hold_left = 600;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Offer one command, optionally after a gap, and hold it until taken.
  task automatic send(logic [CMD_W-1:0] cmd, logic [FRM_W-1:0] f, logic en,
                      logic [CH_W-1:0] ch, logic [VAL_W-1:0] val);
    int gap;
    gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.frame         <= f;
    in_ch.key_enable    <= en;
    in_ch.channel       <= ch;
    in_ch.channel_value <= val;
    // ready is settled mid-cycle; the next rising edge completes the transaction
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) break;
    end
    @(posedge clk_i);
    sent++;
    if (cmd == CMD_EVALUATE) evals++;
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [FRM_W-1:0] pick_frame();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return FRM_W'($urandom_range(0, 300));
    if (sel < 70) return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
    return FRM_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 32'h8000_0000;
    if (sel < 20) return 32'h7FFF_FFFF;
    if (sel < 40) return VAL_W'($urandom_range(0, 131072)) - 32'd65536;
    return $urandom;
  endfunction

  // Mostly edits, stores and evaluates; a little noise and the odd table reset.
  task automatic random_command();
    int sel;
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0] ch;
    sel = $urandom_range(99);
    if (sel < 30) cmd = CMD_SET_CH;
    else if (sel < 48) cmd = CMD_ADD_KEY;
    else if (sel < 56) cmd = CMD_REMOVE;
    else if (sel < 62) cmd = CMD_NEXT_KEY;
    else if (sel < 68) cmd = CMD_PREV_KEY;
    else if (sel < 88) cmd = CMD_EVALUATE;
    else if (sel < 92) cmd = CMD_FIRST_LST;
    else if (sel < 94) cmd = CMD_CLEAR_CUR;
    else if (sel < 95) cmd = CMD_RESET_ALL;
    else cmd = CMD_W'($urandom_range(0, 15));
    ch = ($urandom_range(9) == 0) ? CH_W'($urandom_range(25, 31))
                                  : CH_W'($urandom_range(0, NUM_CH - 1));
    send(cmd, pick_frame(), 1'($urandom_range(1)), ch, pick_value());
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycles = 0;
    sent = 0;
    evals = 0;
    tx_idle = 11;
    rx_idle = 87;
    hold_start = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SET_CH;
    in_ch.frame = '0;
    in_ch.key_enable = 1'b0;
    in_ch.channel = '0;
    in_ch.channel_value = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table first: evaluate, next, previous and remove report an empty table.
    send(CMD_EVALUATE, 16'd5, 1'b0, 5'd0, 32'd0);
    send(CMD_NEXT_KEY, 16'd5, 1'b0, 5'd0, 32'd0);
    send(CMD_PREV_KEY, 16'd5, 1'b0, 5'd0, 32'd0);
    send(CMD_REMOVE, 16'd5, 1'b0, 5'd0, 32'd0);
    send(CMD_FIRST_LST, 16'd0, 1'b0, 5'd0, 32'd0);
    // Node edits at the channel and value extremes; out-of-range channels drop.
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd0, 32'h8000_0000);
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd24, 32'h7FFF_FFFF);
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd25, 32'h1234_5678);
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd31, 32'hFFFF_FFFF);
    send(CMD_ADD_KEY, 16'd0, 1'b1, 5'd0, 32'd0);          // frame raised to one
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd0, 32'h7FFF_FFFF);
    send(CMD_SET_CH, 16'd0, 1'b0, 5'd24, 32'h8000_0000);
    send(CMD_ADD_KEY, 16'hFFFF, 1'b0, 5'd0, 32'd0);
    send(CMD_EVALUATE, 16'h8000, 1'b0, 5'd0, 32'd0);      // interpolate across the span
    send(CMD_EVALUATE, 16'd0, 1'b0, 5'd0, 32'd0);         // before the first key
    send(CMD_EVALUATE, 16'hFFFF, 1'b0, 5'd0, 32'd0);      // exact key
    send(CMD_ADD_KEY, 16'd1, 1'b0, 5'd0, 32'd0);          // overwrite existing key
    send(CMD_NEXT_KEY, 16'hFFFF, 1'b0, 5'd0, 32'd0);      // wraps to first
    send(CMD_PREV_KEY, 16'd0, 1'b0, 5'd0, 32'd0);         // wraps to last
    send(CMD_REMOVE, 16'd77, 1'b0, 5'd0, 32'd0);          // not found
    send(CMD_FIRST_LST, 16'd0, 1'b0, 5'd0, 32'd0);
    send(4'd9, 16'd0, 1'b0, 5'd0, 32'd0);
    send(4'd15, 16'hFFFF, 1'b1, 5'd31, 32'hFFFF_FFFF);
    send(CMD_CLEAR_CUR, 16'd0, 1'b0, 5'd0, 32'd0);
    send(CMD_RESET_ALL, 16'd0, 1'b0, 5'd0, 32'd0);

    // Phase one: sparse receiver, with a long hold-off so the block backs up.
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (150) random_command();
    drain();

    // Phase two: fill the table past its capacity, then mix on a full table.
    tx_idle = 87;
    rx_idle = 11;
    for (int i = 0; i < MAX_KEYS + 2; i++) begin
      send(CMD_SET_CH, 16'd0, 1'b0, CH_W'($urandom_range(0, NUM_CH - 1)), pick_value());
      send(CMD_ADD_KEY, FRM_W'(i * 900 + $urandom_range(1, 899)), 1'($urandom_range(1)),
           5'd0, 32'd0);
    end
    repeat (80) random_command();
    drain();

    // Phase three: no idling on either side.
    tx_idle = 0;
    rx_idle = 0;
    repeat (110) random_command();
    drain();
    repeat (200) @(posedge clk_i);

    $display("Ran %0d commands, %0d of them evaluates, over sparse, stalled and full-rate",
             sent, evals);
    $display("handshakes, an overfilled table and a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
